[sv/wsd_pkg.sv]
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;
   localparam logic [6:0] LEN7_MASK = 7'h7F;
   localparam logic [3:0] OPCODE_MASK = 4'hF;

   // extended-length and key byte counts, minus one
   localparam logic [2:0] EXT16_LAST = 3'd1;
   localparam logic [2:0] EXT64_LAST = 3'd7;
   localparam logic [2:0] KEY_LAST   = 3'd3;   // four-byte mask key

   localparam logic [3:0] OP_CONT   = 4'd0;
   localparam logic [3:0] OP_TEXT   = 4'd1;
   localparam logic [3:0] OP_BINARY = 4'd2;
   localparam logic [3:0] OP_PING   = 4'd9;
   localparam logic [3:0] OP_PONG   = 4'd10;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      EV_PAYLOAD = 2'd0,
      EV_EMPTY   = 2'd1,
      EV_CLOSE   = 2'd2
   } event_type;

   typedef struct packed {
      event_type  kind;
      logic [7:0] raw_byte;
      logic [7:0] key_byte;
      logic [3:0] opcode;
      logic       fin;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type data;
   } push_type;

endpackage

[sv/wsd_if.sv]
// Handshake interfaces for the byte input and the event output channels.
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       conn_start;

   modport source (output valid, output rx_byte, output conn_start, input ready);
   modport sink   (input valid, input rx_byte, input conn_start, output ready);
endinterface

interface wsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [7:0] payload_byte;
   logic [3:0] frame_opcode;
   logic       final_fragment;
   logic       last_of_frame;

   modport source (output valid, output event_kind, output payload_byte,
                   output frame_opcode, output final_fragment, output last_of_frame,
                   input ready);
   modport sink   (input valid, input event_kind, input payload_byte,
                   input frame_opcode, input final_fragment, input last_of_frame,
                   output ready);
endinterface

[sv/wsd_front.sv]
// Header parser: accepts bytes, tracks frame state and classifies each byte.
module wsd_front
   import wsd_pkg::*;
#(
   parameter int LENGTH_BITS = 64
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  logic [7:0] rx_byte,
   input  logic      conn_start,
   input  logic      queue_full,
   output push_type  push_out
);

   phase_type               phase_ff, phase_in, cur_phase;
   logic [3:0]              opcode_ff, opcode_in, cur_opcode;
   logic                    fin_ff, fin_in, cur_fin;
   logic                    masked_ff, masked_in, cur_masked;
   logic [LENGTH_BITS-1:0]  remlen_ff, remlen_in, cur_remlen;
   logic [2:0]              count_ff, count_in, cur_count;
   logic [31:0]             key_ff, key_in, cur_key;
   logic [1:0]              lane_ff, lane_in, cur_lane;
   logic                    closed_ff, closed_in, cur_closed;
   logic                    accept;
   logic [6:0]              len7;
   logic [7:0]              key_sel;

   assign in_ready = !queue_full;
   assign accept   = in_valid && !queue_full;
   assign len7     = rx_byte[6:0] & LEN7_MASK;

   always_comb begin
      case (cur_lane)
         2'd0:    key_sel = cur_key[31:24];
         2'd1:    key_sel = cur_key[23:16];
         2'd2:    key_sel = cur_key[15:8];
         default: key_sel = cur_key[7:0];
      endcase
   end

   always_comb begin
      // a new connection sees the reset state
      cur_phase  = conn_start ? PH_HDR0 : phase_ff;
      cur_opcode = conn_start ? 4'd0 : opcode_ff;
      cur_fin    = conn_start ? 1'b0 : fin_ff;
      cur_masked = conn_start ? 1'b0 : masked_ff;
      cur_remlen = conn_start ? '0 : remlen_ff;
      cur_count  = conn_start ? 3'd0 : count_ff;
      cur_key    = conn_start ? 32'd0 : key_ff;
      cur_lane   = conn_start ? 2'd0 : lane_ff;
      cur_closed = conn_start ? 1'b0 : closed_ff;

      phase_in  = cur_phase;
      opcode_in = cur_opcode;
      fin_in    = cur_fin;
      masked_in = cur_masked;
      remlen_in = cur_remlen;
      count_in  = cur_count;
      key_in    = cur_key;
      lane_in   = cur_lane;
      closed_in = cur_closed;

      push_out.push          = 1'b0;
      push_out.data.kind     = EV_PAYLOAD;
      push_out.data.raw_byte = 8'd0;
      push_out.data.key_byte = 8'd0;
      push_out.data.last     = 1'b0;

      if (!cur_closed) begin
         case (cur_phase)
            PH_HDR1: begin
               masked_in = rx_byte[7];
               remlen_in = '0;
               if (len7 == LEN_EXT16) begin
                  phase_in = PH_EXTLEN;
                  count_in = EXT16_LAST;
               end else if (len7 == LEN_EXT64) begin
                  phase_in = PH_EXTLEN;
                  count_in = EXT64_LAST;
               end else begin
                  remlen_in = {{(LENGTH_BITS-7){1'b0}}, len7};
                  if (rx_byte[7]) begin
                     phase_in = PH_KEY;
                     count_in = KEY_LAST;
                  end else if (len7 == 7'd0) begin
                     phase_in           = PH_HDR0;
                     push_out.push      = 1'b1;
                     push_out.data.kind = EV_EMPTY;
                     push_out.data.last = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_EXTLEN: begin
               if (cur_remlen[LENGTH_BITS-1 -: 8] != 8'd0) begin
                  remlen_in = '1;
               end else begin
                  remlen_in = {cur_remlen[LENGTH_BITS-9:0], rx_byte};
               end
               if (cur_count == 3'd0) begin
                  if (cur_masked) begin
                     phase_in = PH_KEY;
                     count_in = KEY_LAST;
                  end else if (remlen_in == '0) begin
                     phase_in           = PH_HDR0;
                     push_out.push      = 1'b1;
                     push_out.data.kind = EV_EMPTY;
                     push_out.data.last = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  count_in = cur_count - 3'd1;
               end
            end
            PH_KEY: begin
               key_in = {cur_key[23:0], rx_byte};
               if (cur_count == 3'd0) begin
                  if (cur_remlen == '0) begin
                     phase_in           = PH_HDR0;
                     push_out.push      = 1'b1;
                     push_out.data.kind = EV_EMPTY;
                     push_out.data.last = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  count_in = cur_count - 3'd1;
               end
            end
            PH_PAYLOAD: begin
               lane_in                = cur_lane + 2'd1;
               remlen_in              = cur_remlen - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
               push_out.push          = 1'b1;
               push_out.data.raw_byte = rx_byte;
               push_out.data.key_byte = cur_masked ? key_sel : 8'd0;
               if (cur_remlen == {{(LENGTH_BITS-1){1'b0}}, 1'b1}) begin
                  push_out.data.last = 1'b1;
                  phase_in           = PH_HDR0;
               end
            end
            default: begin
               opcode_in = rx_byte[3:0] & OPCODE_MASK;
               fin_in    = rx_byte[7];
               masked_in = 1'b0;
               remlen_in = '0;
               count_in  = 3'd0;
               key_in    = 32'd0;
               lane_in   = 2'd0;
               if (opcode_in inside {OP_CONT, OP_TEXT, OP_BINARY, OP_PING, OP_PONG}) begin
                  phase_in = PH_HDR1;
               end else begin
                  closed_in          = 1'b1;
                  phase_in           = PH_HDR0;
                  push_out.push      = 1'b1;
                  push_out.data.kind = EV_CLOSE;
               end
            end
         endcase
      end

      push_out.data.opcode = opcode_in;
      push_out.data.fin    = fin_in;
      if (!accept) begin
         push_out.push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         opcode_ff <= 4'd0;
         fin_ff    <= 1'b0;
         masked_ff <= 1'b0;
         remlen_ff <= '0;
         count_ff  <= 3'd0;
         key_ff    <= 32'd0;
         lane_ff   <= 2'd0;
         closed_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         fin_ff    <= fin_in;
         masked_ff <= masked_in;
         remlen_ff <= remlen_in;
         count_ff  <= count_in;
         key_ff    <= key_in;
         lane_ff   <= lane_in;
         closed_ff <= closed_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_push_needs_transfer: assert property (@(posedge clock) disable iff (reset)
      push_out.push |-> accept)
      else $error("push without an input transfer");

   a_closed_drops: assert property (@(posedge clock) disable iff (reset)
      (accept && !conn_start && closed_ff) |-> !push_out.push)
      else $error("result from a closed connection");

   a_payload_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remlen_ff != '0))
      else $error("payload phase with zero remaining length");
`endif

endmodule

[sv/wsd_queue.sv]
// Short result queue between the parser and the output stage.
module wsd_queue
   import wsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  push_type  push_in,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type head
);

   entry_type               mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]    wr_ff, rd_ff;
   logic [QPTR_BITS:0]      count_ff, count_in;
   logic                    do_pop;

   assign full      = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      count_in = count_ff;
      if (push_in.push && !do_pop) begin
         count_in = count_ff + (QPTR_BITS+1)'(1);
      end else if (!push_in.push && do_pop) begin
         count_in = count_ff - (QPTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         mem_ff[wr_ff] <= push_in.data;
      end
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push_in.push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push_in.push)
      else $error("push into a full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

[sv/wsd_back.sv]
// Output stage: unmasks payload bytes into the result register.
module wsd_back
   import wsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      not_empty,
   input  entry_type head,
   output logic      pop,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_data,
   output logic [7:0] out_byte
);

   logic       valid_ff;
   entry_type  data_ff;
   logic [7:0] byte_ff, byte_in;

   assign pop       = not_empty && (!valid_ff || out_ready);
   assign byte_in   = (head.kind == EV_PAYLOAD) ? (head.raw_byte ^ head.key_byte) : 8'd0;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_byte  = byte_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= head;
         byte_ff <= byte_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

endmodule

[sv/websocket_frame_deframer_unit.sv]
// Top level of the WebSocket frame deframer.
//
//   channel    dir  handshake      carries
//   req_chan   in   valid/ready    rx_byte, conn_start
//   rsp_chan   out  valid/ready    event_kind, payload_byte, frame_opcode,
//                                  final_fragment, last_of_frame
//
// One byte per cycle while the queue is not full; the parser writes a byte's
// result into the queue at its transfer edge, then the queue loads the output register.
// Each accepted byte updates the parser state, including the 64-bit length decrement.
// A two-entry queue and the output register absorb output stalls; input
// ready drops only when the queue is full.
// Synchronous reset clears parser, queue and output valid.
module websocket_frame_deframer_unit
   import wsd_pkg::*;
#(
   parameter int LENGTH_BITS = 64
) (
   input logic        clock,
   input logic        reset,
   wsd_req_if.sink    req_chan,
   wsd_rsp_if.source  rsp_chan
);

   push_type  push;
   logic      full;
   logic      pop;
   logic      not_empty;
   entry_type head;
   entry_type out_data;

   wsd_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .rx_byte    (req_chan.rx_byte),
      .conn_start (req_chan.conn_start),
      .queue_full (full),
      .push_out   (push)
   );

   wsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   wsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data),
      .out_byte  (rsp_chan.payload_byte)
   );

   assign rsp_chan.event_kind     = out_data.kind;
   assign rsp_chan.frame_opcode   = out_data.opcode;
   assign rsp_chan.final_fragment = out_data.fin;
   assign rsp_chan.last_of_frame  = out_data.last;

endmodule
